// ----- hw/rtl/sst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int INTV_W = 32;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic              periodic;
        logic [INTV_W-1:0] interval;
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   id;
    } entry_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [INTV_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W + 1 - INTV_W){1'b0}}, d};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/software_timer_table.sv -----
// Add: the reply item is valid from the clock edge that takes the item.
// Add, remove and tick each pass every live entry once through the single read
// port of the timer memory. A tick also stalls while a fired item is not taken.
// A refused add or an undefined op does not leave the idle state.
// Reset empties the table and sets the next id to one; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_table #(
    parameter int MAX_TIMERS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // now_ms[47:0], period_ms[79:48], repeat_req[80], remove_id[112:81], zero
    input  wire logic [sst_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  wire logic [sst_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // result_id
    output logic      [sst_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind
    output logic      [sst_pkg::KIND_W-1:0]      m_tuser,
    output logic                                 m_tlast
);

    import sst_pkg::*;

    localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TIMERS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [INTV_W-1:0] interval_reg, interval_next;
    logic              repeat_reg, repeat_next;
    logic [ID_W-1:0]   tid_reg, tid_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  rd_left_reg, rd_left_next;
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]  ev_idx_reg, ev_idx_next;
    logic              hit_reg, hit_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    logic [KIND_W-1:0] m_kind_reg, m_kind_next;
    logic              m_last_reg, m_last_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    entry_t ev_entry, wr_entry;
    logic   out_free, accept, expired, stall;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign ev_entry = entry_t'(ram_rdata);
    assign expired  = ev_entry.deadline <= now_reg;
    assign stall    = (state_reg == ST_RUN) && ev_vld_reg && (op_reg == OP_TICK) &&
                      expired && pend_vld_reg && !out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    sst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_TIMERS)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_ADD) begin
                        state_next = (count_reg < CNT_MAX) ? ST_RUN : ST_IDLE;
                    end else if (s_tuser inside {OP_REMOVE, OP_TICK}) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (rd_left_reg == '0 && !ev_vld_reg) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (!(op_reg == OP_TICK && pend_vld_reg && !out_free)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        op_next       = op_reg;
        now_next      = now_reg;
        interval_next = interval_reg;
        repeat_next   = repeat_reg;
        tid_next      = tid_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_left_next  = rd_left_reg;
        wr_ptr_next   = wr_ptr_reg;
        ev_vld_next   = ev_vld_reg;
        ev_idx_next   = ev_idx_reg;
        hit_next      = hit_reg;
        pend_vld_next = pend_vld_reg;
        pend_id_next  = pend_id_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_id_next     = m_id_reg;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = wr_ptr_reg[IDX_W-1:0];
        ram_raddr     = rd_ptr_reg[IDX_W-1:0];
        wr_entry      = ev_entry;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next       = s_tuser;
                    now_next      = s_tdata[47:0];
                    interval_next = s_tdata[79:48];
                    repeat_next   = s_tdata[80];
                    tid_next      = s_tdata[112:81];
                    rd_left_next  = count_reg;
                    wr_ptr_next   = '0;
                    ev_vld_next   = 1'b0;
                    hit_next      = 1'b0;
                    pend_vld_next = 1'b0;
                    if (s_tuser == OP_ADD) begin
                        rd_ptr_next   = count_reg - 1'b1;
                        m_tvalid_next = 1'b1;
                        m_last_next   = 1'b1;
                        if (count_reg < CNT_MAX) begin
                            m_kind_next = KIND_ADDED;
                            m_id_next   = next_id_reg;
                        end else begin
                            m_kind_next = KIND_REFUSED;
                            m_id_next   = '0;
                        end
                    end else begin
                        rd_ptr_next = '0;
                    end
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    if (ev_vld_reg) begin
                        case (op_reg)
                            OP_ADD: begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(ev_idx_reg + 1'b1);
                            end
                            OP_REMOVE: begin
                                if (!hit_reg && ev_entry.id == tid_reg) begin
                                    hit_next = 1'b1;
                                end else begin
                                    ram_we      = 1'b1;
                                    wr_ptr_next = wr_ptr_reg + 1'b1;
                                end
                            end
                            OP_TICK: begin
                                if (expired) begin
                                    if (pend_vld_reg) begin
                                        m_tvalid_next = 1'b1;
                                        m_kind_next   = KIND_FIRED;
                                        m_id_next     = pend_id_reg;
                                        m_last_next   = 1'b0;
                                    end
                                    pend_vld_next = 1'b1;
                                    pend_id_next  = ev_entry.id;
                                    if (ev_entry.periodic) begin
                                        wr_entry.deadline = sat_add(now_reg, ev_entry.interval);
                                        ram_we            = 1'b1;
                                        wr_ptr_next       = wr_ptr_reg + 1'b1;
                                    end
                                end else begin
                                    ram_we      = 1'b1;
                                    wr_ptr_next = wr_ptr_reg + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    ram_re      = rd_left_reg != '0;
                    ev_vld_next = ram_re;
                    ev_idx_next = rd_ptr_reg[IDX_W-1:0];
                    if (ram_re) begin
                        rd_left_next = rd_left_reg - 1'b1;
                        rd_ptr_next  = (op_reg == OP_ADD) ? rd_ptr_reg - 1'b1
                                                          : rd_ptr_reg + 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                case (op_reg)
                    OP_ADD: begin
                        ram_we            = 1'b1;
                        ram_waddr         = '0;
                        wr_entry.id       = next_id_reg;
                        wr_entry.deadline = sat_add(now_reg, interval_reg);
                        wr_entry.interval = interval_reg;
                        wr_entry.periodic = repeat_reg;
                        count_next        = count_reg + 1'b1;
                        next_id_next      = next_id_reg + 1'b1;
                    end
                    OP_REMOVE: begin
                        count_next = wr_ptr_reg;
                    end
                    OP_TICK: begin
                        count_next = wr_ptr_reg;
                        if (pend_vld_reg && out_free) begin
                            m_tvalid_next = 1'b1;
                            m_kind_next   = KIND_FIRED;
                            m_id_next     = pend_id_reg;
                            m_last_next   = 1'b1;
                            pend_vld_next = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        ram_wdata = wr_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            ev_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rd_left_reg  <= '0;
            hit_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            ev_vld_reg   <= ev_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_left_reg  <= rd_left_next;
            hit_reg      <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        interval_reg <= interval_next;
        repeat_reg   <= repeat_next;
        tid_reg      <= tid_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        ev_idx_reg   <= ev_idx_next;
        pend_id_reg  <= pend_id_next;
        m_id_reg     <= m_id_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("live timer count exceeds the table size");

    a_no_same_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("memory read and write hit the same slot");

    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("fired item left pending after the tick");

    a_id_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL && op_reg == OP_ADD) |=>
            (next_id_reg == ID_W'($past(next_id_reg) + 1'b1)))
        else $error("next id did not advance after an add");

    a_stall_run: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> (ev_vld_reg && state_reg == ST_RUN))
        else $error("entry under evaluation lost during a stall");

endmodule

`default_nettype wire

// ----- hw/rtl/sst_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/timer_table_checker.sv -----
`timescale 1ns / 1ps

module timer_table_checker #(
    parameter int MAX_TIMERS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [sst_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [sst_pkg::OP_W-1:0]        s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [sst_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic [sst_pkg::KIND_W-1:0]      m_tuser,
    input  wire logic                            m_tlast,
    output int                                   fail_count,
    output int                                   pending
);

    import sst_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } timer_event_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
        logic [INTV_W-1:0] period;
        logic              periodic;
    } timer_slot_t;

    timer_slot_t    slots [MAX_TIMERS];
    int             live_cnt;
    logic [ID_W-1:0] id_next;
    timer_event_t   expected_events [$];
    timer_event_t   want;

    function automatic logic [TIME_W-1:0] deadline_of(input logic [TIME_W-1:0] base,
                                                      input logic [INTV_W-1:0] span);
        logic [TIME_W:0] total;
        total = {1'b0, base} + {{(TIME_W + 1 - INTV_W){1'b0}}, span};
        return total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
    endfunction

    // The table stays packed by age, so deleting a slot pulls the older ones up.
    function automatic void drop_slot(input int k);
        int j;
        for (j = k; j + 1 < live_cnt; j++) begin
            slots[j] = slots[j + 1];
        end
        live_cnt--;
    endfunction

    task automatic predict_item(input logic [OP_W-1:0]   op,
                                input logic [TIME_W-1:0] now,
                                input logic [INTV_W-1:0] span,
                                input logic              rep,
                                input logic [ID_W-1:0]   tid);
        int              i;
        bit              found;
        logic [ID_W-1:0] fired_ids [$];
        case (op)
            OP_ADD: begin
                if (live_cnt >= MAX_TIMERS) begin
                    expected_events.push_back('{KIND_REFUSED, '0, 1'b1});
                end else begin
                    for (i = live_cnt; i > 0; i--) begin
                        slots[i] = slots[i - 1];
                    end
                    slots[0] = '{id_next, deadline_of(now, span), span, rep};
                    live_cnt++;
                    expected_events.push_back('{KIND_ADDED, id_next, 1'b1});
                    id_next = id_next + 1'b1;
                end
            end
            OP_REMOVE: begin
                found = 1'b0;
                for (i = 0; i < live_cnt && !found; i++) begin
                    if (slots[i].id == tid) begin
                        drop_slot(i);
                        found = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                i = 0;
                while (i < live_cnt) begin
                    if (slots[i].deadline <= now) begin
                        fired_ids.push_back(slots[i].id);
                        if (slots[i].periodic) begin
                            slots[i].deadline = deadline_of(now, slots[i].period);
                            i++;
                        end else begin
                            drop_slot(i);
                        end
                    end else begin
                        i++;
                    end
                end
                foreach (fired_ids[k]) begin
                    expected_events.push_back('{KIND_FIRED, fired_ids[k],
                                                k == fired_ids.size() - 1});
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            live_cnt   = 0;
            id_next    = ID_W'(1);
            fail_count = 0;
            expected_events.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata[47:0], s_tdata[79:48], s_tdata[80],
                             s_tdata[112:81]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected item: kind %0d id %0d last %0d",
                                 m_tuser, m_tdata, m_tlast);
                    end
                end else begin
                    want = expected_events.pop_front();
                    if (want.kind !== m_tuser || want.id !== m_tdata ||
                        want.last !== m_tlast) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch kind/id/last: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.kind, want.id, want.last,
                                     m_tuser, m_tdata, m_tlast);
                        end
                    end
                end
            end
        end
        pending = expected_events.size();
    end

endmodule

// ----- tb/sv/tb_software_timer_table.sv -----
`timescale 1ns / 1ps

module tb_software_timer_table;
    import sst_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 85;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    int                    fail_total;
    int                    pending_results;
    int                    cycle_cnt = 0;
    int                    idle_mode = 2;
    int                    hold_seq  = 0;
    int                    hold_seen = 0;
    int                    stall_left = 0;
    int                    ids_issued = 0;
    logic [TIME_W-1:0]     clk_ms;

    software_timer_table #(
        .MAX_TIMERS(TABLE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    timer_table_checker #(
        .MAX_TIMERS(TABLE_DEPTH)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_count(fail_total),
        .pending   (pending_results)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("software_timer_table regression: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen  = hold_seq;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else begin
            case (idle_mode)
                0:       m_tready = ($urandom_range(99) >= 63);
                1:       m_tready = ($urandom_range(99) >= 20);
                default: m_tready = 1'b1;
            endcase
        end
    end

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    task automatic send_item(input logic [OP_W-1:0]   op,
                             input logic [TIME_W-1:0] now,
                             input logic [INTV_W-1:0] span,
                             input logic              rep,
                             input logic [ID_W-1:0]   tid);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 20 : (idle_mode == 1) ? 63 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {7'b0, tid, rep, span, now};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        if (op == OP_ADD) begin
            ids_issued++;
        end
    endtask

    // Mostly a realistic schedule: time moves forward, removes aim at issued ids.
    task automatic send_random_item(output bit counted);
        int                r;
        logic [INTV_W-1:0] span;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   tid;
        r = $urandom_range(99);
        counted = 1'b1;
        if (r < 40) begin
            case ($urandom_range(9))
                0:       span = $urandom;
                1:       span = $urandom_range(0, 5);
                default: span = $urandom_range(0, 300);
            endcase
            send_item(OP_ADD, clk_ms, span, 1'($urandom_range(1)), $urandom);
        end else if (r < 75) begin
            if ($urandom_range(19) == 0) begin
                now = rand48();
            end else begin
                clk_ms = clk_ms + TIME_W'($urandom_range(0, 200));
                now    = clk_ms;
            end
            send_item(OP_TICK, now, $urandom, 1'($urandom_range(1)), $urandom);
        end else if (r < 95) begin
            if ($urandom_range(9) == 0) begin
                tid = $urandom;
            end else begin
                tid = $urandom_range(1, ids_issued + 1);
            end
            send_item(OP_REMOVE, rand48(), $urandom, 1'($urandom_range(1)), tid);
        end else begin
            send_item(OP_UNDEFINED, rand48(), $urandom, 1'($urandom_range(1)), $urandom);
            counted = 1'b0;
        end
    endtask

    initial begin
        int n;
        bit counted;
        bit pressed;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ADD;
        aresetn  = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_item(OP_TICK, '0, '0, 1'b0, '0);
        send_item(OP_REMOVE, '0, '0, 1'b0, 32'd5);
        send_item(OP_UNDEFINED, TIME_MAX, '1, 1'b1, '1);
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            case (k)
                0:       send_item(OP_ADD, 48'd1000, 32'd0, 1'b0, '0);
                1:       send_item(OP_ADD, 48'd1000, 32'd0, 1'b1, '1);
                2:       send_item(OP_ADD, 48'd1000, 32'hFFFF_FFFF, 1'b0, '0);
                3:       send_item(OP_ADD, TIME_MAX - 48'd10, 32'd100, 1'b1, '1);
                default: send_item(OP_ADD, 48'd1000, 50 * k, (k % 5) == 0, $urandom);
            endcase
        end
        send_item(OP_ADD, 48'd1000, 32'd7, 1'b1, '0);
        send_item(OP_REMOVE, '0, '0, 1'b0, 32'd3);
        send_item(OP_TICK, 48'd1000, '0, 1'b0, '0);
        send_item(OP_TICK, TIME_MAX - 1'b1, '0, 1'b0, '0);
        send_item(OP_TICK, TIME_MAX, '0, 1'b0, '0);
        send_item(OP_TICK, TIME_MAX, '1, 1'b1, '1);

        clk_ms  = 48'd2000;
        n       = 0;
        pressed = 1'b0;
        while (n < RANDOM_ITEMS) begin
            idle_mode = (n < PHASE_ITEMS) ? 0 : (n < 2 * PHASE_ITEMS) ? 1 : 2;
            if (n >= 2 * PHASE_ITEMS && !pressed) begin
                // Hold the result side off while items keep coming, then drain fully.
                pressed = 1'b1;
                hold_seq++;
                for (int k = 0; k < 6; k++) begin
                    send_item(OP_ADD, clk_ms, $urandom_range(0, 20),
                              1'($urandom_range(1)), $urandom);
                end
                clk_ms = clk_ms + 48'd50;
                send_item(OP_TICK, clk_ms, $urandom, 1'b0, $urandom);
                clk_ms = clk_ms + 48'd25;
                send_item(OP_TICK, clk_ms, $urandom, 1'b1, $urandom);
                n = n + 8;
                s_tvalid = 1'b0;
                wait (pending_results == 0);
                repeat (DRAIN_CYCLES) @(negedge aclk);
            end else begin
                send_random_item(counted);
                if (counted) begin
                    n++;
                end
            end
        end
        s_tvalid = 1'b0;

        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_total == 0) begin
            $display("software_timer_table regression: pass");
        end else begin
            $display("software_timer_table regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/software_timer_table.sv
tb/sv/timer_table_checker.sv
tb/sv/tb_software_timer_table.sv
